### sv/nlp_pkg.sv
// ----------------------------------------------------------------------------
// nlp_pkg
// Shared widths, character codes and digit helpers for the numeric literal
// parser.
// ----------------------------------------------------------------------------
package nlp_pkg;

    localparam int VALUE_WIDTH = 16;
    localparam int CHAR_WIDTH  = 8;
    localparam int COUNT_WIDTH = 2;

    localparam logic [CHAR_WIDTH-1:0] CH_ZERO    = 8'd48;
    localparam logic [CHAR_WIDTH-1:0] CH_NINE    = 8'd57;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_A = 8'd65;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_F = 8'd70;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_A = 8'd97;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_F = 8'd102;
    localparam logic [CHAR_WIDTH-1:0] CH_UPPER_H = 8'd72;
    localparam logic [CHAR_WIDTH-1:0] CH_LOWER_H = 8'd104;
    localparam logic [CHAR_WIDTH-1:0] UPPER_BIAS = 8'd55;
    localparam logic [CHAR_WIDTH-1:0] LOWER_BIAS = 8'd87;

    localparam logic [COUNT_WIDTH-1:0] BYTES_ONE = 2'd1;
    localparam logic [COUNT_WIDTH-1:0] BYTES_TWO = 2'd2;

    typedef logic [VALUE_WIDTH-1:0] t_value;

    typedef struct packed {
        logic       ok;
        logic [3:0] digit;
    } t_digit;

    function automatic t_digit dec_digit(input logic [CHAR_WIDTH-1:0] c);
        t_digit d;
        d.ok    = (c >= CH_ZERO) && (c <= CH_NINE);
        d.digit = d.ok ? 4'(c - CH_ZERO) : 4'd0;
        return d;
    endfunction

    function automatic t_digit hex_digit(input logic [CHAR_WIDTH-1:0] c);
        t_digit d;
        d.ok    = 1'b1;
        d.digit = 4'd0;
        if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
            d.digit = 4'(c - CH_ZERO);
        end else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) begin
            d.digit = 4'(c - UPPER_BIAS);
        end else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) begin
            d.digit = 4'(c - LOWER_BIAS);
        end else begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

### sv/nlp_if.sv
// ----------------------------------------------------------------------------
// nlp_if
// Valid/ready channels of the numeric literal parser: character in,
// converted literal out.
// ----------------------------------------------------------------------------
interface nlp_char_if import nlp_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CHAR_WIDTH-1:0] char_code;
    logic                  last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface nlp_res_if import nlp_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   valid_res;
    logic [VALUE_WIDTH-1:0] value;
    logic [COUNT_WIDTH-1:0] byte_count;

    modport source (output valid, output valid_res, output value, output byte_count,
                    input ready);
    modport sink   (input valid, input valid_res, input value, input byte_count,
                    output ready);
endinterface

### sv/numeric_literal_parser_top.sv
// ----------------------------------------------------------------------------
// numeric_literal_parser_top
// Converts a decimal or H-suffixed hexadecimal ASCII token, one character
// per beat, into a 16-bit value with a byte count.
//
//   channel  dir  payload                          beat
//   i_chr    in   char_code[7:0], last_char        one character of the token
//   o_res    out  valid_res, value[15:0],          one per token, on last char
//                 byte_count[1:0]
//
// One character per cycle sustained, except while a last character waits on a
// stalled o_res. A beat is registered in the input stage, then the digit decode
// and the x10 / x16 update of the running sums (shifts and adds) land in the
// state and result registers. A stall on o_res holds only a last character;
// other characters keep flowing. Reset (i_rst_n low, synchronous) empties both
// stages and restarts the token.
// ----------------------------------------------------------------------------
module numeric_literal_parser_top import nlp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nlp_char_if.sink    i_chr,
    nlp_res_if.source   o_res
);

    // input stage
    logic                  r_s1_valid;
    logic [CHAR_WIDTH-1:0] r_s1_char;
    logic                  r_s1_last;

    // token state
    t_value r_dec_sum, n_dec_sum;
    t_value r_hex_sum, n_hex_sum;
    logic   r_all_dec, n_all_dec;
    logic   r_all_hex, n_all_hex;
    logic   r_seen,    n_seen;

    // result stage
    logic                   r_out_valid;
    logic                   r_out_ok;
    t_value                 r_out_value;
    logic [COUNT_WIDTH-1:0] r_out_count;

    logic                   out_free;
    logic                   s1_fire;
    logic                   in_fire;
    t_digit                 dd;
    t_digit                 hd;
    logic                   suffix;
    t_value                 dec_now;
    logic                   dec_ok;
    logic                   res_ok;
    t_value                 res_value;
    logic [COUNT_WIDTH-1:0] res_count;

    assign out_free    = !r_out_valid || o_res.ready;
    assign s1_fire     = r_s1_valid && (!r_s1_last || out_free);
    assign i_chr.ready = !r_s1_valid || s1_fire;
    assign in_fire     = i_chr.valid && i_chr.ready;

    assign dd      = dec_digit(r_s1_char);
    assign hd      = hex_digit(r_s1_char);
    assign suffix  = (r_s1_char == CH_UPPER_H) || (r_s1_char == CH_LOWER_H);
    assign dec_now = (r_dec_sum << 3) + (r_dec_sum << 1) + t_value'(dd.digit);
    assign dec_ok  = r_all_dec && dd.ok;

    always_comb begin
        if (suffix) begin
            res_ok    = r_seen && r_all_hex;
            res_value = res_ok ? r_hex_sum : '0;
        end else begin
            res_ok    = dec_ok;
            res_value = res_ok ? dec_now : '0;
        end
        res_count = (res_value[VALUE_WIDTH-1:8] != '0) ? BYTES_TWO : BYTES_ONE;
    end

    always_comb begin
        n_dec_sum = r_dec_sum;
        n_hex_sum = r_hex_sum;
        n_all_dec = r_all_dec;
        n_all_hex = r_all_hex;
        n_seen    = r_seen;
        if (s1_fire) begin
            if (r_s1_last) begin
                // token done: restart
                n_dec_sum = '0;
                n_hex_sum = '0;
                n_all_dec = 1'b1;
                n_all_hex = 1'b1;
                n_seen    = 1'b0;
            end else begin
                n_dec_sum = dec_now;
                n_hex_sum = (r_hex_sum << 4) + t_value'(hd.digit);
                n_all_dec = dec_ok;
                n_all_hex = r_all_hex && hd.ok;
                n_seen    = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_dec_sum   <= '0;
            r_hex_sum   <= '0;
            r_all_dec   <= 1'b1;
            r_all_hex   <= 1'b1;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_dec_sum <= n_dec_sum;
            r_hex_sum <= n_hex_sum;
            r_all_dec <= n_all_dec;
            r_all_hex <= n_all_hex;
            r_seen    <= n_seen;

            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end

            if (s1_fire && r_s1_last) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_char <= i_chr.char_code;
            r_s1_last <= i_chr.last_char;
        end
        if (s1_fire && r_s1_last) begin
            r_out_ok    <= res_ok;
            r_out_value <= res_value;
            r_out_count <= res_count;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.valid_res  = r_out_ok;
    assign o_res.value      = r_out_value;
    assign o_res.byte_count = r_out_count;

endmodule
